@@ src/rc2_pkg.sv @@
// RC2 block cipher shared definitions: commands, result kinds, FSM states,
// controller/datapath command struct, PITABLE lookup.
// No dependencies.
package rc2_pkg;

	localparam int KeyBytes = 128;
	localparam int SubKeys = 64;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_EXPAND  = 2'd1,
		CMD_ENCRYPT = 2'd2,
		CMD_DECRYPT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ENC    = 2'd0,
		KIND_DEC    = 2'd1,
		KIND_EXPAND = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FWD_RD,    // forward expansion: issue reads
		ST_FWD_WR,    // forward expansion: write byte
		ST_MID_RD,
		ST_MID_WR,
		ST_BWD_RD,
		ST_BWD_WR,
		ST_SK_RD,     // copy bytes into subkey store
		ST_SK_WR,
		ST_CIPH_RD,   // fetch subkey for next word step
		ST_CIPH_EX,   // apply one word step
		ST_MASH_RD,
		ST_MASH_EX,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // latch input transaction
		logic       key_wr;    // write key byte from input
		logic       kexp_rd;   // issue key store reads for current expansion phase
		logic       kexp_wr;   // write expansion result
		logic [1:0] kexp_ph;   // 0 forward, 1 middle, 2 backward
		logic [6:0] posn;
		logic [6:0] size;
		logic [7:0] mask;
		logic       sk_rd;
		logic       sk_wr;
		logic [5:0] sk_idx;
		logic       ciph_rd;
		logic       ciph_ex;
		logic       mash_rd;
		logic       mash_ex;
		logic       decrypt;
		logic [1:0] word;
		logic [5:0] key_idx;
		logic       out_set;
		logic [1:0] out_kind;
	} ctl_t;

	localparam logic [7:0] PiTab [256] = '{
		8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
		8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
		8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
		8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
		8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
		8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
		8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
		8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
		8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
		8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
		8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
		8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
		8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
		8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
		8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
		8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
	};

endpackage

@@ src/rc2_ctrl.sv @@
// RC2 controller: sequences key load, key expansion and cipher word steps.
// Depends on rc2_pkg.
module rc2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rc2_pkg::cmd_t     in_cmd,
	input  logic [10:0]       key_bits,
	input  logic              out_busy,   // result register still full
	input  logic              out_take,   // result transaction this cycle
	output logic              in_ready,
	output rc2_pkg::ctl_t     ctl
);
	import rc2_pkg::*;

	state_t     state_q, state_nx;
	logic [6:0] posn_q, posn_nx;
	logic [3:0] round_q, round_nx;
	logic [1:0] word_q, word_nx;
	logic       dec_q, dec_nx;
	logic [6:0] size_q;
	logic [7:0] mask_q;
	kind_t      kind_q;
	logic       go;

	// effective key size in bytes and last-byte mask
	logic [10:0] kb;
	logic [7:0]  size_c;
	logic [2:0]  rem_c;
	always_comb begin
		kb = (key_bits == 11'd0) ? 11'd1 : key_bits;
		size_c = kb[10] ? 8'd128 : ({1'b0, kb[9:3]} + {7'd0, kb[2:0] != 3'd0});
		rem_c = kb[2:0];
	end

	// last word step of a round and mash points
	logic last_word, mash_pt;
	always_comb begin
		last_word = dec_q ? (word_q == 2'd0) : (word_q == 2'd3);
		mash_pt = dec_q ? (round_q == 4'd5 || round_q == 4'd11)
		                : (round_q == 4'd4 || round_q == 4'd10);
	end

	assign go = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && (!out_busy || out_take);

	// next state
	always_comb begin
		state_nx = state_q;
		posn_nx = posn_q;
		round_nx = round_q;
		word_nx = word_q;
		dec_nx = dec_q;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					case (in_cmd)
						CMD_EXPAND: begin
							if (size_c[7]) begin
								state_nx = ST_MID_RD;
								posn_nx = 7'd0;
							end else begin
								state_nx = ST_FWD_RD;
								posn_nx = size_c[6:0];
							end
						end
						CMD_ENCRYPT: begin
							state_nx = ST_CIPH_RD;
							dec_nx = 1'b0;
							round_nx = 4'd0;
							word_nx = 2'd0;
						end
						CMD_DECRYPT: begin
							state_nx = ST_CIPH_RD;
							dec_nx = 1'b1;
							round_nx = 4'd15;
							word_nx = 2'd3;
						end
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_FWD_RD: state_nx = ST_FWD_WR;
			ST_FWD_WR: begin
				if (posn_q == 7'd127) begin
					state_nx = ST_MID_RD;
					posn_nx = 7'(8'd128 - {1'b0, size_q});
				end else begin
					state_nx = ST_FWD_RD;
					posn_nx = posn_q + 7'd1;
				end
			end
			ST_MID_RD: state_nx = ST_MID_WR;
			ST_MID_WR: begin
				if (posn_q == 7'd0) begin
					state_nx = ST_SK_RD;
					posn_nx = 7'd0;
				end else begin
					state_nx = ST_BWD_RD;
					posn_nx = posn_q - 7'd1;
				end
			end
			ST_BWD_RD: state_nx = ST_BWD_WR;
			ST_BWD_WR: begin
				if (posn_q == 7'd0) begin
					state_nx = ST_SK_RD;
					posn_nx = 7'd0;
				end else begin
					state_nx = ST_BWD_RD;
					posn_nx = posn_q - 7'd1;
				end
			end
			ST_SK_RD: state_nx = ST_SK_WR;
			ST_SK_WR: begin
				posn_nx = posn_q + 7'd1;
				state_nx = (posn_q == 7'd63) ? ST_OUT : ST_SK_RD;
			end
			ST_CIPH_RD: state_nx = ST_CIPH_EX;
			ST_CIPH_EX: begin
				if (dec_q) begin
					if (!last_word) begin
						word_nx = word_q - 2'd1;
						state_nx = ST_CIPH_RD;
					end else begin
						word_nx = 2'd3;
						if (mash_pt) state_nx = ST_MASH_RD;
						else if (round_q == 4'd0) state_nx = ST_OUT;
						else begin
							round_nx = round_q - 4'd1;
							state_nx = ST_CIPH_RD;
						end
					end
				end else begin
					word_nx = word_q + 2'd1;
					if (!last_word) state_nx = ST_CIPH_RD;
					else if (mash_pt) state_nx = ST_MASH_RD;
					else if (round_q == 4'd15) state_nx = ST_OUT;
					else begin
						round_nx = round_q + 4'd1;
						state_nx = ST_CIPH_RD;
					end
				end
			end
			ST_MASH_RD: state_nx = ST_MASH_EX;
			ST_MASH_EX: begin
				if (dec_q) begin
					if (word_q != 2'd0) begin
						word_nx = word_q - 2'd1;
						state_nx = ST_MASH_RD;
					end else begin
						word_nx = 2'd3;
						round_nx = round_q - 4'd1;
						state_nx = ST_CIPH_RD;
					end
				end else begin
					word_nx = word_q + 2'd1;
					if (word_q != 2'd3) state_nx = ST_MASH_RD;
					else begin
						round_nx = round_q + 4'd1;
						state_nx = ST_CIPH_RD;
					end
				end
			end
			ST_OUT: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			posn_q <= '0;
			round_q <= '0;
			word_q <= '0;
			dec_q <= 1'b0;
			size_q <= '0;
			mask_q <= '0;
			kind_q <= KIND_ENC;
		end else begin
			state_q <= state_nx;
			posn_q <= posn_nx;
			round_q <= round_nx;
			word_q <= word_nx;
			dec_q <= dec_nx;
			if (go) begin
				kind_q <= (in_cmd == CMD_EXPAND) ? KIND_EXPAND :
					((in_cmd == CMD_DECRYPT) ? KIND_DEC : KIND_ENC);
			end
			if (go && in_cmd == CMD_EXPAND) begin
				size_q <= size_c[6:0];
				mask_q <= (kb[10] || rem_c == 3'd0) ? 8'hFF :
					8'((9'd1 << rem_c) - 9'd1);
			end
		end
	end

	// datapath commands
	always_comb begin
		ctl = '0;
		ctl.load = go;
		ctl.key_wr = go && in_cmd == CMD_WRITE;
		ctl.posn = posn_q;
		ctl.size = size_q;
		ctl.mask = mask_q;
		ctl.sk_idx = posn_q[5:0];
		ctl.decrypt = dec_q;
		ctl.word = word_q;
		ctl.key_idx = {round_q, word_q};
		ctl.out_kind = kind_q;
		case (state_q)
			ST_FWD_RD: begin ctl.kexp_rd = 1'b1; ctl.kexp_ph = 2'd0; end
			ST_FWD_WR: begin ctl.kexp_wr = 1'b1; ctl.kexp_ph = 2'd0; end
			ST_MID_RD: begin ctl.kexp_rd = 1'b1; ctl.kexp_ph = 2'd1; end
			ST_MID_WR: begin ctl.kexp_wr = 1'b1; ctl.kexp_ph = 2'd1; end
			ST_BWD_RD: begin ctl.kexp_rd = 1'b1; ctl.kexp_ph = 2'd2; end
			ST_BWD_WR: begin ctl.kexp_wr = 1'b1; ctl.kexp_ph = 2'd2; end
			ST_SK_RD: ctl.sk_rd = 1'b1;
			ST_SK_WR: ctl.sk_wr = 1'b1;
			ST_CIPH_RD: ctl.ciph_rd = 1'b1;
			ST_CIPH_EX: ctl.ciph_ex = 1'b1;
			ST_MASH_RD: ctl.mash_rd = 1'b1;
			ST_MASH_EX: ctl.mash_ex = 1'b1;
			ST_OUT: ctl.out_set = 1'b1;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_go_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(go && in_cmd != CMD_WRITE) |=> state_q != ST_IDLE) else $error("command lost");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> state_q == ST_IDLE) else $error("out state stuck");
endmodule

@@ src/rc2_dp.sv @@
// RC2 datapath: key byte store, subkey store, cipher word register and
// result register. Depends on rc2_pkg.
module rc2_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rc2_pkg::ctl_t     ctl,
	input  logic [6:0]        key_index,
	input  logic [7:0]        key_byte,
	input  logic [63:0]       block_in,
	input  logic              out_take,
	output logic              out_busy,
	output logic [63:0]       block_out,
	output logic [1:0]        result_kind
);
	import rc2_pkg::*;

	logic [7:0]  kmem [KeyBytes];
	logic [15:0] smem [SubKeys];
	logic [7:0]  rd_a_q, rd_b_q;
	logic [15:0] sk_q;
	logic [15:0] w_q [4];
	logic        busy_q;
	logic [63:0] res_q;
	logic [1:0]  kind_q;

	// key store read addresses
	logic [6:0] addr_a, addr_b, addr_w;
	always_comb begin
		addr_a = ctl.posn;
		addr_b = ctl.posn;
		addr_w = ctl.posn;
		case (ctl.kexp_ph)
			2'd0: begin addr_a = ctl.posn - 7'd1; addr_b = ctl.posn - ctl.size; end
			2'd2: begin addr_a = ctl.posn + 7'd1; addr_b = ctl.posn + ctl.size; end
			default: ;
		endcase
		if (ctl.sk_rd) begin
			addr_a = {ctl.sk_idx, 1'b0};
			addr_b = {ctl.sk_idx, 1'b1};
		end
		if (ctl.key_wr) addr_w = key_index;
	end

	logic [7:0] pi_idx, kwr_data;
	always_comb begin
		case (ctl.kexp_ph)
			2'd0: pi_idx = rd_a_q + rd_b_q;
			2'd1: pi_idx = rd_a_q & ctl.mask;
			default: pi_idx = rd_a_q ^ rd_b_q;
		endcase
		kwr_data = ctl.key_wr ? key_byte : PiTab[pi_idx];
	end

	// key byte store
	always_ff @(posedge clk) begin
		if (ctl.kexp_rd || ctl.sk_rd) begin
			rd_a_q <= kmem[addr_a];
			rd_b_q <= kmem[addr_b];
		end
		if (ctl.key_wr || ctl.kexp_wr) kmem[addr_w] <= kwr_data;
	end

	// word step arithmetic
	logic [1:0]  wi;
	logic [15:0] wa, wb, wc, wcur, mix, v, wnew;
	logic [5:0]  sk_raddr;
	logic [3:0]  sh;
	always_comb begin
		wi = ctl.word;
		wa = w_q[wi + 2'd3];
		wb = w_q[wi + 2'd2];
		wc = w_q[wi + 2'd1];
		wcur = w_q[wi];
		mix = (wa & wb) + (~wa & wc);
		case (wi)
			2'd0: sh = 4'd1;
			2'd1: sh = 4'd2;
			2'd2: sh = 4'd3;
			default: sh = 4'd5;
		endcase
		if (ctl.decrypt) begin
			v = (wcur >> sh) | (wcur << (5'd16 - {1'b0, sh}));
			wnew = v - sk_q - mix;
		end else begin
			v = wcur + sk_q + mix;
			wnew = (v << sh) | (v >> (5'd16 - {1'b0, sh}));
		end
		sk_raddr = ctl.mash_rd ? wa[5:0] : ctl.key_idx;
	end

	// subkey store
	always_ff @(posedge clk) begin
		if (ctl.ciph_rd || ctl.mash_rd) sk_q <= smem[sk_raddr];
		if (ctl.sk_wr) smem[ctl.sk_idx] <= {rd_b_q, rd_a_q};
	end

	// block words
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			w_q[0] <= block_in[15:0];
			w_q[1] <= block_in[31:16];
			w_q[2] <= block_in[47:32];
			w_q[3] <= block_in[63:48];
		end else if (ctl.ciph_ex) begin
			w_q[wi] <= wnew;
		end else if (ctl.mash_ex) begin
			w_q[wi] <= ctl.decrypt ? wcur - sk_q : wcur + sk_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (ctl.out_set) busy_q <= 1'b1;
		else if (out_take) busy_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (ctl.out_set) begin
			res_q <= (ctl.out_kind == KIND_EXPAND) ? 64'd0 :
				{w_q[3], w_q[2], w_q[1], w_q[0]};
			kind_q <= ctl.out_kind;
		end
	end

	assign out_busy = busy_q;
	assign block_out = res_q;
	assign result_kind = kind_q;

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_set |-> (!busy_q || out_take)) else $error("result overwritten");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.key_wr && ctl.kexp_wr)) else $error("key store write clash");
	a_busy_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_set |=> busy_q) else $error("result not held");
endmodule

@@ src/rc2_block_cipher_unit.sv @@
// RC2 (64-bit block) cipher unit, top level.
// Encrypt/decrypt: each word step is a subkey read, then an update; 64 mix + 8 mash
// steps plus the result load; no new block is taken before the last result is taken.
// Expand: key expansion from the effective key size in bytes, then the subkey copy.
// Key byte write: no result. One transaction at a time. arst_n clears control
// and the result flag; key_bits resets to 64; key and subkey stores undefined until written.
module rc2_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic [79:0] s_tdata,   // key_index[6:0], key_byte[14:7], block_in[78:15], pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // block_out[63:0]
	output logic [1:0]  m_tuser    // result_kind[1:0]
);
	import rc2_pkg::*;

	logic [10:0] key_bits_q;
	ctl_t        ctl;
	logic        out_busy, out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_bits_q <= 11'd64;
		else if (cfg_we) key_bits_q <= cfg_wdata;
	end

	assign out_take = m_tvalid && m_tready;
	assign m_tvalid = out_busy;

	rc2_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid),
		.in_cmd(cmd_t'(s_tuser)), .key_bits(key_bits_q),
		.out_busy(out_busy), .out_take(out_take), .in_ready(s_tready), .ctl(ctl)
	);

	rc2_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.key_index(s_tdata[6:0]), .key_byte(s_tdata[14:7]),
		.block_in(s_tdata[78:15]), .out_take(out_take), .out_busy(out_busy),
		.block_out(m_tdata), .result_kind(m_tuser)
	);
endmodule
